// ----- rtl/core/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// shared constants and stage payload types of the vector compress pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam int NUM_ELEMS = 16;
  localparam int ELEM_W    = 8;
  localparam int HALF      = NUM_ELEMS / 2;
  localparam int VEC_W     = NUM_ELEMS * ELEM_W;
  localparam int IDX_W     = $clog2(NUM_ELEMS);
  localparam int LPOS_W    = $clog2(HALF);
  localparam int HCNT_W    = $clog2(HALF) + 1;
  localparam int CNT_W     = IDX_W + 1;

  localparam logic [5:0]        CMP_FUNCT6 = 6'h17;
  localparam logic [2:0]        CMP_FUNCT3 = 3'h2;
  localparam logic [2:0]        EW_8BIT    = 3'd0;
  localparam logic [ELEM_W-1:0] TAIL_FILL  = 8'hFF;

  // stage 1: decoded word
  typedef struct packed {
    logic                 en;
    logic                 ta;
    logic [NUM_ELEMS-1:0] mask;
    logic [VEC_W-1:0]     src;
    logic [VEC_W-1:0]     old;
  } s1_t;

  // stage 2: half-local prefix positions and half counts
  typedef struct packed {
    logic                             en;
    logic                             ta;
    logic [NUM_ELEMS-1:0]             mask;
    logic [NUM_ELEMS-1:0][LPOS_W-1:0] lpos;
    logic [HCNT_W-1:0]                cnt_lo;
    logic [CNT_W-1:0]                 cnt;
    logic [VEC_W-1:0]                 src;
    logic [VEC_W-1:0]                 old;
  } s2_t;

endpackage

`default_nettype wire

// ----- rtl/core/cbm_prefix.sv -----
// ----------------------------------------------------------------------------
// cbm_prefix
// prefix count of kept elements, per eight-element half, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_prefix import cbm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic vld_in,
  input  wire s1_t  s1_in,
  output logic      vld_out,
  output s2_t       s2_out
);

  logic vld_r;
  s2_t  s2_r;
  s2_t  s2_nxt;

  always_comb begin
    logic [HCNT_W-1:0] run;
    logic [HCNT_W-1:0] hcnt [2];
    s2_nxt.en   = s1_in.en;
    s2_nxt.ta   = s1_in.ta;
    s2_nxt.mask = s1_in.mask;
    s2_nxt.src  = s1_in.src;
    s2_nxt.old  = s1_in.old;
    for (int h = 0; h < 2; h++) begin
      run = '0;
      for (int j = 0; j < HALF; j++) begin
        s2_nxt.lpos[h*HALF + j] = run[LPOS_W-1:0];
        run = run + HCNT_W'(s1_in.mask[h*HALF + j]);
      end
      hcnt[h] = run;
    end
    s2_nxt.cnt_lo = hcnt[0];
    s2_nxt.cnt    = CNT_W'(hcnt[0]) + CNT_W'(hcnt[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign vld_out = vld_r;
  assign s2_out  = s2_r;

endmodule

`default_nettype wire

// ----- rtl/core/cbm_pack.sv -----
// ----------------------------------------------------------------------------
// cbm_pack
// byte placement by destination index, tail fill and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_pack import cbm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_in,
  input  wire s2_t               s2_in,
  output logic                   vld_out,
  output logic [VEC_W-1:0]       res_out
);

  logic             vld_r;
  logic [VEC_W-1:0] res_r;
  logic [VEC_W-1:0] res_nxt;

  always_comb begin
    logic [IDX_W-1:0]  gpos [NUM_ELEMS];
    logic [ELEM_W-1:0] byte_v;
    // global destination index: high half is offset by the low half count
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (i >= HALF) begin
        gpos[i] = IDX_W'(s2_in.lpos[i]) + IDX_W'(s2_in.cnt_lo);
      end else begin
        gpos[i] = IDX_W'(s2_in.lpos[i]);
      end
    end
    for (int p = 0; p < NUM_ELEMS; p++) begin
      byte_v = '0;
      if (CNT_W'(p) >= s2_in.cnt) begin
        byte_v = s2_in.ta ? TAIL_FILL : s2_in.old[p*ELEM_W +: ELEM_W];
      end else begin
        for (int i = 0; i < NUM_ELEMS; i++) begin
          if (s2_in.mask[i] && (gpos[i] == IDX_W'(p))) begin
            byte_v = byte_v | s2_in.src[i*ELEM_W +: ELEM_W];
          end
        end
      end
      res_nxt[p*ELEM_W +: ELEM_W] = s2_in.en ? byte_v : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign vld_out = vld_r;
  assign res_out = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/vector_compress_by_mask.sv -----
// ----------------------------------------------------------------------------
// vector_compress_by_mask
// three-stage pipelined vector compress of sixteen 8-bit elements
// ----------------------------------------------------------------------------
// a word accepted by start passes the decode, prefix count and byte placement
//   registers in that order on its way to the out_ ports
// throughput: one word per cycle, set by the fully pipelined prefix and mux
// busy is tied low: no stall is needed since the receiver cannot hold results off
// reset (synchronous, rst_n low) clears the stage valid bits only
`default_nettype none

module vector_compress_by_mask import cbm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [5:0]  in_funct6,
  input  wire logic [2:0]  in_funct3,
  input  wire logic [6:0]  in_start_index,
  input  wire logic [7:0]  in_vector_length,
  input  wire logic [2:0]  in_element_width_code,
  input  wire logic        in_tail_agnostic,
  input  wire logic [63:0] in_source_low,
  input  wire logic [63:0] in_source_high,
  input  wire logic [63:0] in_old_low,
  input  wire logic [63:0] in_old_high,
  input  wire logic [15:0] in_select_mask,
  output logic             out_valid,
  output logic [63:0]      out_result_low,
  output logic [63:0]      out_result_high
);

  // stage 1 registers: decoded operation, active element mask and operand vectors
  logic s1_vld_r;
  s1_t  s1_r;
  s1_t  s1_nxt;

  logic s2_vld;
  s2_t  s2;

  logic [VEC_W-1:0] res;

  assign busy = 1'b0;

  // decode: the op computes only for a compress at element 0 with 8-bit
  // elements; elements at or beyond vl are dropped from the mask
  always_comb begin
    logic [NUM_ELEMS-1:0] act;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      act[i] = (8'(i) < in_vector_length);
    end
    s1_nxt.en   = (in_funct6 == CMP_FUNCT6) && (in_funct3 == CMP_FUNCT3) &&
                  (in_start_index == '0) && (in_element_width_code == EW_8BIT);
    s1_nxt.ta   = in_tail_agnostic;
    s1_nxt.mask = in_select_mask & act;
    s1_nxt.src  = {in_source_high, in_source_low};
    s1_nxt.old  = {in_old_high, in_old_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // stage 2: per-half prefix counts of kept elements
  cbm_prefix u_prefix (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (s1_vld_r),
    .s1_in   (s1_r),
    .vld_out (s2_vld),
    .s2_out  (s2)
  );

  // stage 3: place kept bytes, fill the tail, register the result word
  cbm_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (s2_vld),
    .s2_in   (s2),
    .vld_out (out_valid),
    .res_out (res)
  );

  assign out_result_low  = res[63:0];
  assign out_result_high = res[VEC_W-1:64];

  // a result strobe always traces back to an accepted word through the decode, prefix and pack registers
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without an accepted word");

  // stage 2 valid is the registered stage 1 valid
  a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld |-> $past(s1_vld_r))
    else $error("stage 2 valid without stage 1 valid");

  // a non-compress or unsupported op yields an all-zero result
  a_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld && !s2.en) |=> (out_result_low == '0) && (out_result_high == '0))
    else $error("nonzero result for a disabled op");

  // a compress with nothing kept and agnostic tail gives all ones
  a_all_tail_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld && s2.en && s2.ta && (s2.mask == '0)) |=>
      (out_result_low == '1) && (out_result_high == '1))
    else $error("agnostic tail not filled");

endmodule

`default_nettype wire
